/* hdl/tsrc_pkg.sv */
package tsrc_pkg;

   typedef enum logic [2:0] {
      REQ_INIT    = 3'd0,
      REQ_MEASURE = 3'd1,
      REQ_READ    = 3'd2,
      REQ_WR_ACK  = 3'd3,
      REQ_DLY_END = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      ACT_READ   = 2'd0,
      ACT_WRITE  = 2'd1,
      ACT_DELAY  = 2'd2,
      ACT_REPORT = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_INVALID = 3'd1,
      ST_NO_DEV  = 3'd2,
      ST_TIMEOUT = 3'd3,
      ST_NO_DATA = 3'd4,
      ST_RANGE   = 3'd5,
      ST_BUS_ERR = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      DLY_NONE,
      DLY_POLL,
      DLY_SETTLE,
      DLY_CONV
   } dly_sel_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_ID_RD,
      SEQ_RST_WR,
      SEQ_RST_DL,
      SEQ_IPOLL_RD,
      SEQ_IPOLL_DL,
      SEQ_CAL_RD,
      SEQ_HUM_WR,
      SEQ_MEAS_WR,
      SEQ_MEAS_DL,
      SEQ_MPOLL_RD,
      SEQ_MPOLL_DL,
      SEQ_DATA_RD
   } seq_state_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_DECIDE,
      PH_CALCHK,
      PH_CALC1,
      PH_CALC2,
      PH_CALC3,
      PH_OUT
   } phase_type;

   typedef enum logic [1:0] {
      CSR_POLL_LIMIT = 2'd0,
      CSR_POLL_DELAY = 2'd1,
      CSR_SETTLE     = 2'd2,
      CSR_CONV_WAIT  = 2'd3
   } csr_index_type;

   localparam logic [7:0]  ADDR_CHIP_ID   = 8'hd0;
   localparam logic [7:0]  CHIP_ID_VALUE  = 8'h60;
   localparam logic [7:0]  ADDR_RESET     = 8'he0;
   localparam logic [7:0]  RESET_CMD      = 8'hb6;
   localparam logic [7:0]  ADDR_STATUS    = 8'hf3;
   localparam logic [7:0]  ADDR_CALIB     = 8'h88;
   localparam logic [7:0]  ADDR_CTRL_HUM  = 8'hf2;
   localparam logic [7:0]  HUM_OFF        = 8'h00;
   localparam logic [7:0]  ADDR_CTRL_MEAS = 8'hf4;
   localparam logic [7:0]  MEAS_CMD       = 8'h21;
   localparam logic [7:0]  ADDR_DATA      = 8'hfa;
   localparam logic [19:0] ADC_SKIP       = 20'h80000;
   localparam logic [27:0] ROUND_BIAS     = 28'd128;
   localparam logic [15:0] CAL_ALL_ONES   = 16'hffff;
   localparam logic [2:0]  LEN_ONE        = 3'd1;
   localparam logic [2:0]  LEN_DATA       = 3'd3;
   localparam logic [2:0]  LEN_CALIB      = 3'd6;
   localparam logic [2:0]  IDX_CAL_LAST   = 3'd5;
   localparam logic [2:0]  IDX_DATA_LAST  = 3'd2;

   localparam logic [5:0] POLL_LIMIT_RST = 6'd50;
   localparam logic [4:0] POLL_DELAY_RST = 5'd2;
   localparam logic [4:0] SETTLE_RST     = 5'd3;
   localparam logic [4:0] CONV_WAIT_RST  = 5'd10;

   typedef struct packed {
      logic [5:0] poll_limit;
      logic [4:0] poll_delay_ms;
      logic [4:0] reset_settle_ms;
      logic [4:0] conversion_wait_ms;
   } cfg_type;

   typedef struct packed {
      logic        latch;
      logic        clear_buf;
      logic        push_byte;
      logic        store_cal;
      logic        clear_cal;
      logic        poll_clear;
      logic        poll_inc;
      logic        out_load;
      action_type  out_action;
      logic [7:0]  out_addr;
      logic [7:0]  out_wval;
      logic [2:0]  out_len;
      dly_sel_type out_dsel;
      status_type  out_status;
      logic        out_temp_en;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       bus_error;
      logic       id_ok;
      logic       stat_bit0;
      logic       stat_bit3;
      logic [2:0] byte_index;
      logic       cal_bad;
      logic       adc_skip;
      logic       temp_bad;
      logic       poll_at_limit;
      logic       poll_limit_zero;
      logic       out_busy;
   } dp_stat_type;

endpackage

/* hdl/tsrc_csr.sv */
module tsrc_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [3:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready,
   output tsrc_pkg::cfg_type cfg
);
   import tsrc_pkg::*;

   cfg_type cfg_ff;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_limit         <= POLL_LIMIT_RST;
         cfg_ff.poll_delay_ms      <= POLL_DELAY_RST;
         cfg_ff.reset_settle_ms    <= SETTLE_RST;
         cfg_ff.conversion_wait_ms <= CONV_WAIT_RST;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            CSR_POLL_LIMIT: cfg_ff.poll_limit         <= csr_pwdata[5:0];
            CSR_POLL_DELAY: cfg_ff.poll_delay_ms      <= csr_pwdata[4:0];
            CSR_SETTLE:     cfg_ff.reset_settle_ms    <= csr_pwdata[4:0];
            CSR_CONV_WAIT:  cfg_ff.conversion_wait_ms <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_POLL_LIMIT: csr_prdata = {26'd0, cfg_ff.poll_limit};
         CSR_POLL_DELAY: csr_prdata = {27'd0, cfg_ff.poll_delay_ms};
         CSR_SETTLE:     csr_prdata = {27'd0, cfg_ff.reset_settle_ms};
         CSR_CONV_WAIT:  csr_prdata = {27'd0, cfg_ff.conversion_wait_ms};
         default:        csr_prdata = 32'd0;
      endcase
   end

endmodule

/* hdl/tsrc_dp.sv */
module tsrc_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  tsrc_pkg::cfg_type     cfg,
   input  tsrc_pkg::dp_cmd_type  cmd,
   output tsrc_pkg::dp_stat_type stat,
   input  logic [2:0]            req_tuser,
   input  logic [15:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_tuser,
   output logic [47:0]           rsp_tdata
);
   import tsrc_pkg::*;

   logic [2:0]  rq_ff;
   logic [7:0]  rb_ff;
   logic        err_ff;
   logic [7:0]  byte_buf_ff [6];
   logic [2:0]  idx_ff;
   logic [15:0] cal_t1_ff, cal_t2_ff, cal_t3_ff;
   logic [5:0]  poll_cnt_ff;

   logic [19:0]        adc;
   logic [15:0]        buf_t1, buf_t2;
   logic signed [17:0] a1;
   logic signed [16:0] d;
   logic signed [15:0] t2s, t3s;
   logic signed [33:0] p1_ff, dd_ff;
   logic signed [22:0] v1_ff;
   logic signed [21:0] dd_sh;
   logic signed [37:0] p3_ff;
   logic signed [23:0] v2;
   logic signed [24:0] sum;
   logic signed [27:0] sum_x, s5;
   logic signed [19:0] t_val;
   logic [14:0]        temp_ff;
   logic               temp_bad_ff;

   logic        out_valid_ff;
   logic [1:0]  out_action_ff;
   logic [41:0] out_data_ff;
   logic [4:0]  dly;

   // sensor sample and calibration views
   assign adc    = {byte_buf_ff[0], byte_buf_ff[1], byte_buf_ff[2][7:4]};
   assign buf_t1 = {byte_buf_ff[1], byte_buf_ff[0]};
   assign buf_t2 = {byte_buf_ff[3], byte_buf_ff[2]};

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         rq_ff  <= req_tuser;
         rb_ff  <= req_tdata[7:0];
         err_ff <= req_tdata[8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else if (cmd.clear_buf) begin
         idx_ff <= 3'd0;
      end else if (cmd.push_byte) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_byte && idx_ff < LEN_CALIB) begin
         byte_buf_ff[idx_ff] <= rb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_cal) begin
         cal_t1_ff <= 16'd0;
         cal_t2_ff <= 16'd0;
         cal_t3_ff <= 16'd0;
      end else if (cmd.store_cal) begin
         cal_t1_ff <= buf_t1;
         cal_t2_ff <= buf_t2;
         cal_t3_ff <= {byte_buf_ff[5], byte_buf_ff[4]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_cnt_ff <= 6'd0;
      end else if (cmd.poll_clear) begin
         poll_cnt_ff <= cmd.poll_inc ? 6'd1 : 6'd0;
      end else if (cmd.poll_inc) begin
         poll_cnt_ff <= poll_cnt_ff + 6'd1;
      end
   end

   // compensation pipeline, three register stages
   assign t2s   = $signed(cal_t2_ff);
   assign t3s   = $signed(cal_t3_ff);
   assign a1    = $signed({1'b0, adc[19:3]}) - $signed({1'b0, cal_t1_ff, 1'b0});
   assign d     = $signed({1'b0, adc[19:4]}) - $signed({1'b0, cal_t1_ff});
   assign dd_sh = dd_ff[33:12];
   assign v2    = p3_ff[37:14];
   assign sum   = {v1_ff[22], v1_ff[22], v1_ff} + {v2[23], v2};
   assign sum_x = {{3{sum[24]}}, sum};
   assign s5    = (sum_x <<< 2) + sum_x + $signed(ROUND_BIAS);
   assign t_val = s5[27:8];

   always_ff @(posedge clock) begin
      p1_ff       <= a1 * t2s;
      dd_ff       <= d * d;
      v1_ff       <= p1_ff[33:11];
      p3_ff       <= dd_sh * t3s;
      temp_ff     <= t_val[14:0];
      temp_bad_ff <= (t_val < -20'sd4000) || (t_val > 20'sd8500);
   end

   always_comb begin
      case (cmd.out_dsel)
         DLY_POLL:   dly = cfg.poll_delay_ms;
         DLY_SETTLE: dly = cfg.reset_settle_ms;
         DLY_CONV:   dly = cfg.conversion_wait_ms;
         default:    dly = 5'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_action_ff <= cmd.out_action;
         out_data_ff   <= {(cmd.out_temp_en ? temp_ff : 15'd0), cmd.out_status, dly,
                           cmd.out_len, cmd.out_wval, cmd.out_addr};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_action_ff;
   assign rsp_tdata  = {6'd0, out_data_ff};

   assign stat.req_type        = rq_ff;
   assign stat.bus_error       = err_ff;
   assign stat.id_ok           = (rb_ff == CHIP_ID_VALUE);
   assign stat.stat_bit0       = rb_ff[0];
   assign stat.stat_bit3       = rb_ff[3];
   assign stat.byte_index      = idx_ff;
   assign stat.cal_bad         = (buf_t1 == 16'd0) || (buf_t1 == CAL_ALL_ONES) ||
                                 (buf_t2 == 16'd0);
   assign stat.adc_skip        = (adc == ADC_SKIP);
   assign stat.temp_bad        = temp_bad_ff;
   assign stat.poll_at_limit   = (poll_cnt_ff >= cfg.poll_limit);
   assign stat.poll_limit_zero = (cfg.poll_limit == 6'd0);
   assign stat.out_busy        = out_valid_ff & ~rsp_tready;

endmodule

/* hdl/tsrc_ctrl.sv */
module tsrc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  tsrc_pkg::dp_stat_type stat,
   output tsrc_pkg::dp_cmd_type  cmd
);
   import tsrc_pkg::*;

   phase_type     phase_ff, phase_in;
   seq_state_type seq_ff, seq_in;
   logic          ready_ff, ready_in;
   logic          limit_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         seq_ff   <= SEQ_IDLE;
         ready_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         seq_ff   <= seq_in;
         ready_ff <= ready_in;
      end
   end

   assign limit_hit = (seq_ff inside {SEQ_RST_DL, SEQ_MEAS_DL}) ?
                      stat.poll_limit_zero : stat.poll_at_limit;

   always_comb begin
      cmd        = '0;
      phase_in   = phase_ff;
      seq_in     = seq_ff;
      ready_in   = ready_ff;
      req_tready = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               phase_in  = PH_DECIDE;
            end
         end
         PH_DECIDE: begin
            if (!stat.out_busy) begin
               phase_in = PH_IDLE;
               case (stat.req_type)
                  REQ_INIT: begin
                     if (seq_ff == SEQ_IDLE) begin
                        ready_in      = 1'b0;
                        cmd.clear_cal = 1'b1;
                        cmd.clear_buf = 1'b1;
                        cmd.out_load  = 1'b1;
                        cmd.out_action = ACT_READ;
                        cmd.out_addr  = ADDR_CHIP_ID;
                        cmd.out_len   = LEN_ONE;
                        seq_in        = SEQ_ID_RD;
                     end
                  end
                  REQ_MEASURE: begin
                     if (seq_ff == SEQ_IDLE) begin
                        cmd.out_load = 1'b1;
                        if (!ready_ff) begin
                           cmd.out_action = ACT_REPORT;
                           cmd.out_status = ST_INVALID;
                        end else begin
                           cmd.out_action = ACT_WRITE;
                           cmd.out_addr   = ADDR_CTRL_MEAS;
                           cmd.out_wval   = MEAS_CMD;
                           seq_in         = SEQ_MEAS_WR;
                        end
                     end
                  end
                  REQ_READ: begin
                     if (seq_ff inside {SEQ_ID_RD, SEQ_IPOLL_RD, SEQ_CAL_RD, SEQ_MPOLL_RD,
                                        SEQ_DATA_RD}) begin
                        if (stat.bus_error) begin
                           cmd.out_load   = 1'b1;
                           cmd.out_action = ACT_REPORT;
                           cmd.out_status = ST_BUS_ERR;
                           seq_in         = SEQ_IDLE;
                        end else begin
                           case (seq_ff)
                              SEQ_ID_RD: begin
                                 cmd.out_load = 1'b1;
                                 if (stat.id_ok) begin
                                    cmd.out_action = ACT_WRITE;
                                    cmd.out_addr   = ADDR_RESET;
                                    cmd.out_wval   = RESET_CMD;
                                    seq_in         = SEQ_RST_WR;
                                 end else begin
                                    cmd.out_action = ACT_REPORT;
                                    cmd.out_status = ST_NO_DEV;
                                    seq_in         = SEQ_IDLE;
                                 end
                              end
                              SEQ_IPOLL_RD: begin
                                 cmd.out_load = 1'b1;
                                 if (!stat.stat_bit0) begin
                                    cmd.clear_buf  = 1'b1;
                                    cmd.out_action = ACT_READ;
                                    cmd.out_addr   = ADDR_CALIB;
                                    cmd.out_len    = LEN_CALIB;
                                    seq_in         = SEQ_CAL_RD;
                                 end else begin
                                    cmd.out_action = ACT_DELAY;
                                    cmd.out_dsel   = DLY_POLL;
                                    seq_in         = SEQ_IPOLL_DL;
                                 end
                              end
                              SEQ_MPOLL_RD: begin
                                 cmd.out_load = 1'b1;
                                 if (!stat.stat_bit3) begin
                                    cmd.clear_buf  = 1'b1;
                                    cmd.out_action = ACT_READ;
                                    cmd.out_addr   = ADDR_DATA;
                                    cmd.out_len    = LEN_DATA;
                                    seq_in         = SEQ_DATA_RD;
                                 end else begin
                                    cmd.out_action = ACT_DELAY;
                                    cmd.out_dsel   = DLY_POLL;
                                    seq_in         = SEQ_MPOLL_DL;
                                 end
                              end
                              SEQ_CAL_RD: begin
                                 cmd.push_byte = 1'b1;
                                 if (stat.byte_index == IDX_CAL_LAST) begin
                                    phase_in = PH_CALCHK;
                                 end
                              end
                              default: begin
                                 cmd.push_byte = 1'b1;
                                 if (stat.byte_index == IDX_DATA_LAST) begin
                                    phase_in = PH_CALC1;
                                 end
                              end
                           endcase
                        end
                     end
                  end
                  REQ_WR_ACK: begin
                     if (seq_ff inside {SEQ_RST_WR, SEQ_HUM_WR, SEQ_MEAS_WR}) begin
                        cmd.out_load = 1'b1;
                        if (stat.bus_error) begin
                           cmd.out_action = ACT_REPORT;
                           cmd.out_status = ST_BUS_ERR;
                           seq_in         = SEQ_IDLE;
                        end else if (seq_ff == SEQ_RST_WR) begin
                           cmd.out_action = ACT_DELAY;
                           cmd.out_dsel   = DLY_SETTLE;
                           seq_in         = SEQ_RST_DL;
                        end else if (seq_ff == SEQ_MEAS_WR) begin
                           cmd.out_action = ACT_DELAY;
                           cmd.out_dsel   = DLY_CONV;
                           seq_in         = SEQ_MEAS_DL;
                        end else begin
                           ready_in       = 1'b1;
                           cmd.out_action = ACT_REPORT;
                           cmd.out_status = ST_OK;
                           seq_in         = SEQ_IDLE;
                        end
                     end
                  end
                  REQ_DLY_END: begin
                     if (seq_ff inside {SEQ_RST_DL, SEQ_MEAS_DL, SEQ_IPOLL_DL,
                                        SEQ_MPOLL_DL}) begin
                        cmd.out_load   = 1'b1;
                        cmd.poll_clear = (seq_ff inside {SEQ_RST_DL, SEQ_MEAS_DL});
                        if (limit_hit) begin
                           cmd.out_action = ACT_REPORT;
                           cmd.out_status = ST_TIMEOUT;
                           seq_in         = SEQ_IDLE;
                        end else begin
                           cmd.poll_inc   = 1'b1;
                           cmd.clear_buf  = 1'b1;
                           cmd.out_action = ACT_READ;
                           cmd.out_addr   = ADDR_STATUS;
                           cmd.out_len    = LEN_ONE;
                           seq_in = (seq_ff inside {SEQ_MEAS_DL, SEQ_MPOLL_DL}) ?
                                    SEQ_MPOLL_RD : SEQ_IPOLL_RD;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         PH_CALCHK: begin
            if (!stat.out_busy) begin
               cmd.store_cal = 1'b1;
               cmd.out_load  = 1'b1;
               phase_in      = PH_IDLE;
               if (stat.cal_bad) begin
                  cmd.out_action = ACT_REPORT;
                  cmd.out_status = ST_INVALID;
                  seq_in         = SEQ_IDLE;
               end else begin
                  cmd.out_action = ACT_WRITE;
                  cmd.out_addr   = ADDR_CTRL_HUM;
                  cmd.out_wval   = HUM_OFF;
                  seq_in         = SEQ_HUM_WR;
               end
            end
         end
         PH_CALC1: phase_in = PH_CALC2;
         PH_CALC2: phase_in = PH_CALC3;
         PH_CALC3: phase_in = PH_OUT;
         PH_OUT: begin
            if (!stat.out_busy) begin
               cmd.out_load   = 1'b1;
               cmd.out_action = ACT_REPORT;
               seq_in         = SEQ_IDLE;
               phase_in       = PH_IDLE;
               if (stat.adc_skip) begin
                  cmd.out_status = ST_NO_DATA;
               end else if (stat.temp_bad) begin
                  cmd.out_status = ST_RANGE;
               end else begin
                  cmd.out_status  = ST_OK;
                  cmd.out_temp_en = 1'b1;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

endmodule

/* hdl/temp_sensor_readout_controller.sv */
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tuser request kind, tdata byte and error flag
// rsp       out        rsp_tvalid/rsp_tready  tuser action, tdata address, value, status...
// csr       in         apb psel/penable       four config registers at 0x0, 0x4, 0x8, 0xc
//
// an item is accepted, then decided on and loaded into the output register
// the last data byte of a measurement then passes the three compensation pipeline stages
// and the final report; the last calibration byte passes the calibration check
// reset clears the sequencer, ready flag and output valid; config returns to defaults
// a result waiting on rsp holds the decide step; req_tready is low until it moves
module temp_sensor_readout_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // req_type
   input  logic [15:0] req_tdata,   // read_byte, bus_error
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // action
   output logic [47:0] rsp_tdata,   // reg_addr, write_value, read_length, delay_ms,
                                    // status, temperature
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tsrc_pkg::*;

   cfg_type     cfg;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   tsrc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tsrc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import tsrc_pkg::*;

   localparam int         PHASES      = 8;
   localparam int         PHASE_ITEMS = 115;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         SETTLE_CYC  = 20;
   localparam logic [2:0] REQ_UNUSED  = 3'd7;

   typedef struct packed {
      action_type  act;
      logic [7:0]  addr;
      logic [7:0]  wval;
      logic [2:0]  len;
      logic [4:0]  dly;
      status_type  st;
      logic [14:0] temp;
   } sensor_rsp_type;

   typedef struct {
      logic [2:0]     kind;
      logic [7:0]     data;
      bit             err;
      bit             typed;
      sensor_rsp_type want;
   } stim_row_type;

   localparam sensor_rsp_type NO_RSP = '0;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [2:0]  req_tuser;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [1:0]  rsp_tuser;
   logic [47:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   temp_sensor_readout_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // sequencer shadow
   seq_state_type seq_st;
   bit            ready_q;
   logic [15:0]   t1_q, t2_q, t3_q;
   logic [5:0]    poll_cnt;
   logic [47:0]   byte_buf;
   logic [2:0]    byte_idx;
   cfg_type       cfg;

   sensor_rsp_type pending_rsp[$];
   bit             failed;
   int             err_shown;
   int             cycles;
   bit             idle_on;
   int             busy_pct;
   logic [47:0]    cal_words;
   logic [23:0]    adc_bytes;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic sensor_rsp_type rsp_fields(action_type a, logic [7:0] ad,
                                                 logic [7:0] wv, logic [2:0] ln,
                                                 logic [4:0] dl, status_type s,
                                                 logic [14:0] tp);
      sensor_rsp_type r;
      r.act  = a;
      r.addr = ad;
      r.wval = wv;
      r.len  = ln;
      r.dly  = dl;
      r.st   = s;
      r.temp = tp;
      return r;
   endfunction

   function automatic stim_row_type stim(logic [2:0] kind, logic [7:0] data, bit err, bit typed,
                                         sensor_rsp_type want);
      stim_row_type s;
      s.kind  = kind;
      s.data  = data;
      s.err   = err;
      s.typed = typed;
      s.want  = want;
      return s;
   endfunction

   task automatic advance_sequencer(input logic [2:0] kind, input logic [7:0] rb, input bit err,
                                    output bit taken, output bit got, output sensor_rsp_type r);
      bit     meas;
      longint adc, t1, t2, t3, v1, d, v2, tc;
      taken = 1'b0;
      got   = 1'b0;
      r     = NO_RSP;
      case (kind)
         REQ_INIT, REQ_MEASURE: begin
            if (seq_st == SEQ_IDLE) begin
               taken = 1'b1;
               got   = 1'b1;
               if (kind == REQ_INIT) begin
                  ready_q  = 1'b0;
                  t1_q     = '0;
                  t2_q     = '0;
                  t3_q     = '0;
                  byte_buf = '0;
                  byte_idx = '0;
                  seq_st   = SEQ_ID_RD;
                  r = rsp_fields(ACT_READ, ADDR_CHIP_ID, 8'h00, LEN_ONE, 5'd0, ST_OK, 15'd0);
               end else if (!ready_q) begin
                  r = rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_INVALID, 15'd0);
               end else begin
                  seq_st = SEQ_MEAS_WR;
                  r = rsp_fields(ACT_WRITE, ADDR_CTRL_MEAS, MEAS_CMD, 3'd0, 5'd0, ST_OK, 15'd0);
               end
            end
         end
         REQ_READ: begin
            if (seq_st inside {SEQ_ID_RD, SEQ_IPOLL_RD, SEQ_CAL_RD, SEQ_MPOLL_RD,
                               SEQ_DATA_RD}) begin
               taken = 1'b1;
               if (err) begin
                  got    = 1'b1;
                  seq_st = SEQ_IDLE;
                  r = rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_BUS_ERR, 15'd0);
               end else if (seq_st == SEQ_ID_RD) begin
                  got = 1'b1;
                  if (rb != CHIP_ID_VALUE) begin
                     seq_st = SEQ_IDLE;
                     r = rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_NO_DEV, 15'd0);
                  end else begin
                     seq_st = SEQ_RST_WR;
                     r = rsp_fields(ACT_WRITE, ADDR_RESET, RESET_CMD, 3'd0, 5'd0, ST_OK, 15'd0);
                  end
               end else if (seq_st inside {SEQ_IPOLL_RD, SEQ_MPOLL_RD}) begin
                  got  = 1'b1;
                  meas = (seq_st == SEQ_MPOLL_RD);
                  if ((meas ? rb[3] : rb[0]) == 1'b0) begin
                     byte_buf = '0;
                     byte_idx = '0;
                     if (meas) begin
                        seq_st = SEQ_DATA_RD;
                        r = rsp_fields(ACT_READ, ADDR_DATA, 8'h00, LEN_DATA, 5'd0, ST_OK, 15'd0);
                     end else begin
                        seq_st = SEQ_CAL_RD;
                        r = rsp_fields(ACT_READ, ADDR_CALIB, 8'h00, LEN_CALIB, 5'd0, ST_OK,
                                       15'd0);
                     end
                  end else begin
                     if (meas) seq_st = SEQ_MPOLL_DL;
                     else seq_st = SEQ_IPOLL_DL;
                     r = rsp_fields(ACT_DELAY, 8'h00, 8'h00, 3'd0, cfg.poll_delay_ms, ST_OK, 15'd0);
                  end
               end else begin
                  byte_buf[8*byte_idx +: 8] = rb;
                  byte_idx = byte_idx + 3'd1;
                  if (seq_st == SEQ_DATA_RD) begin
                     if (byte_idx == LEN_DATA) begin
                        got    = 1'b1;
                        seq_st = SEQ_IDLE;
                        adc = longint'({byte_buf[7:0], byte_buf[15:8], byte_buf[23:20]});
                        t1  = longint'(t1_q);
                        t2  = longint'($signed(t2_q));
                        t3  = longint'($signed(t3_q));
                        v1  = (((adc >>> 3) - t1 * 2) * t2) >>> 11;
                        d   = (adc >>> 4) - t1;
                        v2  = (((d * d) >>> 12) * t3) >>> 14;
                        tc  = ((v1 + v2) * 5 + 128) >>> 8;
                        if (adc == longint'(ADC_SKIP))
                           r = rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_NO_DATA, 15'd0);
                        else if (tc < -4000 || tc > 8500)
                           r = rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_RANGE, 15'd0);
                        else
                           r = rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_OK, tc[14:0]);
                     end
                  end else if (byte_idx == LEN_CALIB) begin
                     got  = 1'b1;
                     t1_q = byte_buf[15:0];
                     t2_q = byte_buf[31:16];
                     t3_q = byte_buf[47:32];
                     if (t1_q == '0 || t1_q == CAL_ALL_ONES || t2_q == '0) begin
                        seq_st = SEQ_IDLE;
                        r = rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_INVALID, 15'd0);
                     end else begin
                        seq_st = SEQ_HUM_WR;
                        r = rsp_fields(ACT_WRITE, ADDR_CTRL_HUM, HUM_OFF, 3'd0, 5'd0, ST_OK,
                                       15'd0);
                     end
                  end
               end
            end
         end
         REQ_WR_ACK: begin
            if (seq_st inside {SEQ_RST_WR, SEQ_HUM_WR, SEQ_MEAS_WR}) begin
               taken = 1'b1;
               got   = 1'b1;
               if (err) begin
                  seq_st = SEQ_IDLE;
                  r = rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_BUS_ERR, 15'd0);
               end else if (seq_st == SEQ_RST_WR) begin
                  seq_st = SEQ_RST_DL;
                  r = rsp_fields(ACT_DELAY, 8'h00, 8'h00, 3'd0, cfg.reset_settle_ms, ST_OK, 15'd0);
               end else if (seq_st == SEQ_MEAS_WR) begin
                  seq_st = SEQ_MEAS_DL;
                  r = rsp_fields(ACT_DELAY, 8'h00, 8'h00, 3'd0, cfg.conversion_wait_ms, ST_OK,
                                 15'd0);
               end else begin
                  seq_st  = SEQ_IDLE;
                  ready_q = 1'b1;
                  r = rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_OK, 15'd0);
               end
            end
         end
         REQ_DLY_END: begin
            if (seq_st inside {SEQ_RST_DL, SEQ_MEAS_DL, SEQ_IPOLL_DL, SEQ_MPOLL_DL}) begin
               taken = 1'b1;
               got   = 1'b1;
               meas  = seq_st inside {SEQ_MEAS_DL, SEQ_MPOLL_DL};
               if (seq_st inside {SEQ_RST_DL, SEQ_MEAS_DL}) poll_cnt = '0;
               if (poll_cnt >= cfg.poll_limit) begin
                  seq_st = SEQ_IDLE;
                  r = rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_TIMEOUT, 15'd0);
               end else begin
                  poll_cnt = poll_cnt + 6'd1;
                  byte_buf = '0;
                  byte_idx = '0;
                  if (meas) seq_st = SEQ_MPOLL_RD;
                  else seq_st = SEQ_IPOLL_RD;
                  r = rsp_fields(ACT_READ, ADDR_STATUS, 8'h00, LEN_ONE, 5'd0, ST_OK, 15'd0);
               end
            end
         end
         default: ;
      endcase
   endtask

   // mostly the answer the sequencer waits for, with some noise
   task automatic pick_req(input bit tidy, output logic [2:0] kind, output logic [7:0] data,
                           output bit err);
      logic [19:0] adc;
      int          roll;
      kind = REQ_READ;
      data = 8'($urandom);
      err  = ($urandom_range(0, 99) < 3);
      if (!tidy && $urandom_range(0, 99) < 10) begin
         kind = 3'($urandom_range(0, 7));
         err  = 1'($urandom_range(0, 1));
      end else begin
         case (seq_st)
            SEQ_IDLE: begin
               err = 1'($urandom_range(0, 1));
               if (ready_q ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) == 0))
                  kind = REQ_MEASURE;
               else
                  kind = REQ_INIT;
            end
            SEQ_ID_RD: if ($urandom_range(0, 9) != 0) data = CHIP_ID_VALUE;
            SEQ_RST_WR, SEQ_HUM_WR, SEQ_MEAS_WR: kind = REQ_WR_ACK;
            SEQ_RST_DL, SEQ_IPOLL_DL, SEQ_MEAS_DL, SEQ_MPOLL_DL: begin
               kind = REQ_DLY_END;
               err  = 1'($urandom_range(0, 1));
            end
            SEQ_IPOLL_RD: data[0] = ($urandom_range(0, 99) < busy_pct);
            SEQ_MPOLL_RD: data[3] = ($urandom_range(0, 99) < busy_pct);
            SEQ_CAL_RD: begin
               if (byte_idx == '0) begin
                  roll = $urandom_range(0, 99);
                  if (roll < 70) begin
                     cal_words[15:0]  = 16'($urandom_range(26000, 29000));
                     cal_words[31:16] = 16'($urandom_range(25000, 27500));
                     cal_words[47:32] = 16'hfc18 + 16'($urandom_range(0, 1100));
                  end else begin
                     cal_words = {16'($urandom), 32'($urandom)};
                     if (roll >= 90) begin
                        case ($urandom_range(0, 2))
                           0: cal_words[15:0] = '0;
                           1: cal_words[15:0] = CAL_ALL_ONES;
                           default: cal_words[31:16] = '0;
                        endcase
                     end
                  end
               end
               data = cal_words[8*byte_idx +: 8];
            end
            SEQ_DATA_RD: begin
               if (byte_idx == '0) begin
                  roll = $urandom_range(0, 99);
                  if (roll < 10) adc = ADC_SKIP;
                  else if (roll < 15) adc = '0;
                  else if (roll < 20) adc = '1;
                  else adc = 20'($urandom);
                  adc_bytes = {adc[3:0], 4'($urandom), adc[11:4], adc[19:12]};
               end
               data = adc_bytes[8*byte_idx +: 8];
            end
            default: ;
         endcase
      end
   endtask

   task automatic send_req(input logic [2:0] kind, input logic [7:0] data, input bit err,
                           input bit typed, input sensor_rsp_type want, output bit taken);
      bit             got;
      sensor_rsp_type r;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, err, data};
      do @(posedge clock); while (!req_tready);
      advance_sequencer(kind, data, err, taken, got, r);
      if (typed) pending_rsp.push_back(want);
      else if (got) pending_rsp.push_back(r);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         CSR_POLL_LIMIT: cfg.poll_limit         = 6'(value);
         CSR_POLL_DELAY: cfg.poll_delay_ms      = 5'(value);
         CSR_SETTLE:     cfg.reset_settle_ms    = 5'(value);
         CSR_CONV_WAIT:  cfg.conversion_wait_ms = 5'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         failed = 1'b1;
         if (err_shown < 40) $error("%s: expected %0d, got %0d", name, want, got);
         err_shown++;
      end
   endtask

   // receiver back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      sensor_rsp_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            failed = 1'b1;
            if (err_shown < 40) $error("unexpected transaction, action %0d", rsp_tuser);
            err_shown++;
         end else begin
            w = pending_rsp.pop_front();
            check_field("action", w.act, rsp_tuser);
            check_field("reg_addr", w.addr, rsp_tdata[7:0]);
            check_field("write_value", w.wval, rsp_tdata[15:8]);
            check_field("read_length", w.len, rsp_tdata[18:16]);
            check_field("delay_ms", w.dly, rsp_tdata[23:19]);
            check_field("status", w.st, rsp_tdata[26:24]);
            check_field("temperature", longint'($signed(w.temp)),
                        longint'($signed(rsp_tdata[41:27])));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("temp_sensor_readout_controller regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type rows[$];
      logic [2:0]   kind;
      logic [7:0]   data;
      bit           err;
      bit           taken;
      int           ph;
      int           n;
      int           lim, pdl, stl, cnv;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = REQ_INIT;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      failed      = 1'b0;
      err_shown   = 0;
      cycles      = 0;
      idle_on     = 1'b1;
      busy_pct    = 50;
      cal_words   = '0;
      adc_bytes   = '0;
      seq_st      = SEQ_IDLE;
      ready_q     = 1'b0;
      t1_q        = '0;
      t2_q        = '0;
      t3_q        = '0;
      poll_cnt    = '0;
      byte_buf    = '0;
      byte_idx    = '0;
      cfg         = {POLL_LIMIT_RST, POLL_DELAY_RST, SETTLE_RST, CONV_WAIT_RST};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: measure before init, ignored items, failed inits, full init, skipped reading
      rows.push_back(stim(REQ_MEASURE, 8'h00, 1'b0, 1'b1,
         rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_INVALID, 15'd0)));
      rows.push_back(stim(REQ_READ, 8'hff, 1'b1, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_UNUSED, 8'h00, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_DLY_END, 8'h00, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_INIT, 8'h00, 1'b0, 1'b1,
         rsp_fields(ACT_READ, ADDR_CHIP_ID, 8'h00, LEN_ONE, 5'd0, ST_OK, 15'd0)));
      rows.push_back(stim(REQ_INIT, 8'h00, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_WR_ACK, 8'h00, 1'b1, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'h5f, 1'b0, 1'b1,
         rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_NO_DEV, 15'd0)));
      rows.push_back(stim(REQ_INIT, 8'h00, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, CHIP_ID_VALUE, 1'b1, 1'b1,
         rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_BUS_ERR, 15'd0)));
      rows.push_back(stim(REQ_INIT, 8'h00, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, CHIP_ID_VALUE, 1'b0, 1'b1,
         rsp_fields(ACT_WRITE, ADDR_RESET, RESET_CMD, 3'd0, 5'd0, ST_OK, 15'd0)));
      rows.push_back(stim(REQ_WR_ACK, 8'h00, 1'b0, 1'b1,
         rsp_fields(ACT_DELAY, 8'h00, 8'h00, 3'd0, SETTLE_RST, ST_OK, 15'd0)));
      rows.push_back(stim(REQ_DLY_END, 8'h00, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'hff, 1'b0, 1'b1,
         rsp_fields(ACT_DELAY, 8'h00, 8'h00, 3'd0, POLL_DELAY_RST, ST_OK, 15'd0)));
      rows.push_back(stim(REQ_DLY_END, 8'h00, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'hfe, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'h70, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'h6b, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'h43, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'h67, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'h18, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'hfc, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_WR_ACK, 8'h00, 1'b0, 1'b1,
         rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_OK, 15'd0)));
      rows.push_back(stim(REQ_MEASURE, 8'h00, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_WR_ACK, 8'h00, 1'b0, 1'b1,
         rsp_fields(ACT_DELAY, 8'h00, 8'h00, 3'd0, CONV_WAIT_RST, ST_OK, 15'd0)));
      rows.push_back(stim(REQ_DLY_END, 8'h00, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'h00, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'h80, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'h00, 1'b0, 1'b0, NO_RSP));
      rows.push_back(stim(REQ_READ, 8'h00, 1'b0, 1'b1,
         rsp_fields(ACT_REPORT, 8'h00, 8'h00, 3'd0, 5'd0, ST_NO_DATA, 15'd0)));

      foreach (rows[i]) send_req(rows[i].kind, rows[i].data, rows[i].err, rows[i].typed,
                                 rows[i].want, taken);

      for (ph = 0; ph < PHASES; ph++) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         while (pending_rsp.size() != 0) @(posedge clock);
         repeat (SETTLE_CYC) @(posedge clock);
         lim = $urandom_range(1, 63);
         pdl = $urandom_range(0, 31);
         stl = $urandom_range(0, 31);
         cnv = $urandom_range(0, 31);
         busy_pct = 40;
         case (ph)
            0: begin
               lim = 50; pdl = 2; stl = 3; cnv = 10; busy_pct = 50;
            end
            1: begin
               lim = 1; pdl = 0; stl = 0; cnv = 0; busy_pct = 30;
            end
            2: begin
               lim = 63; pdl = 31; stl = 31; cnv = 31; busy_pct = 70;
            end
            3: lim = 0;
            4: begin
               lim = 3; busy_pct = 85;
            end
            default: ;
         endcase
         write_csr(CSR_POLL_LIMIT, lim);
         write_csr(CSR_POLL_DELAY, pdl);
         write_csr(CSR_SETTLE, stl);
         write_csr(CSR_CONV_WAIT, cnv);
         idle_on = (ph % 3 != 1) && (ph != PHASES - 1);
         n = 0;
         while (n < PHASE_ITEMS) begin
            pick_req(1'b0, kind, data, err);
            send_req(kind, data, err, 1'b0, NO_RSP, taken);
            n += taken;
         end
         // run the open sequence to its report before the next setting
         while (seq_st != SEQ_IDLE) begin
            pick_req(1'b1, kind, data, err);
            send_req(kind, data, err, 1'b0, NO_RSP, taken);
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (!failed)
         $display("temp_sensor_readout_controller regression: pass");
      else
         $display("temp_sensor_readout_controller regression: fail");
      $finish;
   end

endmodule
